[src/linear_scan_register_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the linear scan register allocator
// Shared clocking and reset wrappers for concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef LINEAR_SCAN_REGISTER_ALLOCATOR_DEFINES_SVH
`define LINEAR_SCAN_REGISTER_ALLOCATOR_DEFINES_SVH

// check on every clock edge outside reset
`define LSRA_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    prop) else $error(msg);

// check on every clock edge, reset included
`define LSRA_ASSERT_ALWAYS(lbl, prop, msg) lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[src/lsra_pkg.sv]
// ----------------------------------------------------------------------------
// lsra_pkg
// Types and codes shared by the register allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsra_pkg;

    localparam int ADDR_W = 6;
    localparam int REG_W  = 6;

    localparam logic [1:0] ST_REG      = 2'd0;
    localparam logic [1:0] ST_SPILL    = 2'd1;
    localparam logic [1:0] ST_UNUSED   = 2'd2;
    localparam logic [1:0] ST_CONFLICT = 2'd3;

    localparam logic [1:0] CFG_ARG_COUNT = 2'd0;
    localparam logic [1:0] CFG_ROTATE    = 2'd1;

    typedef struct packed {
        logic [15:0]      end_pos;
        logic [7:0]       var_num;
        logic [REG_W-1:0] reg_num;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

`default_nettype wire

[src/linear_scan_register_allocator.sv]
// Per interval, expired entries leave the active set, the scan skips busy registers and entries shift to make room.
// One interval is handled at a time; the walks over the active set memory set how long each takes.
// A waiting result does not block acceptance of the next interval.
// Reset: asynchronous, clears the active set count, busy map, configuration and output valid.
// ----------------------------------------------------------------------------
// linear_scan_register_allocator
// Linear scan register allocation over a sorted active set held in memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_scan_register_allocator #(
    parameter int NUM_REGS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // interval_begin, interval_end, var_id
    input  wire logic        s_axis_tuser,   // starts_function
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // out_var, reg_index
    output logic [1:0]       m_axis_tuser,   // status
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_data
);

    localparam int AW = $clog2(NUM_REGS);
    localparam int CW = $clog2(NUM_REGS + 1);
    localparam logic [CW-1:0] FULL = CW'(NUM_REGS);
    localparam logic [7:0] NV8 = 8'(NUM_REGS);

    typedef enum logic [3:0] {
        S_IDLE, S_EXP_CHK, S_DECIDE, S_SCAN, S_SPILL_CHK,
        S_INS_START, S_INS_CHK, S_INS_WR, S_EMIT
    } state_t;

    state_t state_reg;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] ins_pos_reg;
    logic [AW-1:0] scan_reg;
    logic [NUM_REGS-1:0] busy_reg;
    logic [4:0] arg_reg;
    logic [3:0] rot_reg;

    logic signed [16:0] beg_reg;
    logic [15:0] end_reg;
    logic [7:0]  var_reg;
    logic [AW-1:0] new_reg_reg;

    logic [7:0]    res0_var_reg, res1_var_reg;
    logic [1:0]    res0_st_reg, res1_st_reg;
    logic [AW-1:0] res0_reg_reg, res1_reg_reg;
    logic          two_reg;
    logic          sent_reg;

    logic       m_valid_reg;
    logic [7:0] m_var_reg;
    logic [1:0] m_st_reg;
    logic [3:0] m_idx_reg;
    logic       m_last_reg;

    lsra_pkg::mem_req_t req;
    lsra_pkg::entry_t   rd_data;
    lsra_pkg::entry_t   new_entry;

    logic          in_fire;
    logic          in_start;
    logic signed [16:0] in_beg;
    logic [AW-1:0] head_eff;
    logic [CW-1:0] count_eff;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] rd_reg;
    logic          expire_hit;
    logic          is_fixed;
    logic          fixed_bad;
    logic          out_free;
    logic [7:0]    sel_var;
    logic [1:0]    sel_st;
    logic [AW-1:0] sel_reg;
    logic [3:0]    sel_idx;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] pos);
        logic [AW:0] s;
        s = {1'b0, head} + (AW+1)'(pos);
        if (s >= (AW+1)'(NUM_REGS))
        begin
            s = s - (AW+1)'(NUM_REGS);
        end
        return s[AW-1:0];
    endfunction

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_start      = s_axis_tuser;
    assign in_beg        = s_axis_tdata[16:0];
    assign head_eff      = in_start ? '0 : head_reg;
    assign count_eff     = in_start ? '0 : count_reg;
    assign head_inc      = phys(head_reg, CW'(1));
    assign rd_reg        = rd_data.reg_num[AW-1:0];
    assign expire_hit    = $signed({1'b0, rd_data.end_pos}) < beg_reg;
    assign is_fixed      = var_reg < {3'b000, arg_reg};
    assign fixed_bad     = (var_reg >= NV8) || busy_reg[var_reg[AW-1:0]];
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign new_entry.end_pos = end_reg;
    assign new_entry.var_num = var_reg;
    assign new_entry.reg_num = lsra_pkg::REG_W'(new_reg_reg);

    assign sel_var = sent_reg ? res1_var_reg : res0_var_reg;
    assign sel_st  = sent_reg ? res1_st_reg  : res0_st_reg;
    assign sel_reg = sent_reg ? res1_reg_reg : res0_reg_reg;

    lsra_rot #(.NUM_REGS(NUM_REGS)) u_rot (
        .rot       (rot_reg),
        .reg_num   (sel_reg),
        .reg_index (sel_idx)
    );

    lsra_mem #(.DEPTH(NUM_REGS)) u_mem (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    always_comb
    begin
        req       = '0;
        req.wdata = rd_data;
        unique case (state_reg)
            S_IDLE:
            begin
                req.raddr = lsra_pkg::ADDR_W'(head_eff);
            end
            S_EXP_CHK:
            begin
                req.raddr = lsra_pkg::ADDR_W'(head_inc);
            end
            S_DECIDE, S_INS_START:
            begin
                req.raddr = lsra_pkg::ADDR_W'(phys(head_reg, count_reg - CW'(1)));
            end
            S_INS_CHK:
            begin
                req.we    = (rd_data.end_pos >= end_reg);
                req.waddr = lsra_pkg::ADDR_W'(phys(head_reg, pos_reg + CW'(1)));
                req.raddr = lsra_pkg::ADDR_W'(phys(head_reg, pos_reg - CW'(1)));
            end
            S_INS_WR:
            begin
                req.we    = 1'b1;
                req.waddr = lsra_pkg::ADDR_W'(phys(head_reg, ins_pos_reg));
                req.wdata = new_entry;
            end
            default:
            begin
                req.raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            busy_reg    <= '0;
            arg_reg     <= '0;
            rot_reg     <= '0;
            two_reg     <= 1'b0;
            sent_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == lsra_pkg::CFG_ARG_COUNT)
                begin
                    arg_reg <= cfg_data;
                end
                else if (cfg_index == lsra_pkg::CFG_ROTATE)
                begin
                    rot_reg <= cfg_data[3:0];
                end
            end
            if (m_axis_tvalid && m_axis_tready && (state_reg != S_EMIT))
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        beg_reg  <= in_beg;
                        end_reg  <= s_axis_tdata[32:17];
                        var_reg  <= s_axis_tdata[40:33];
                        two_reg  <= 1'b0;
                        sent_reg <= 1'b0;
                        if (in_start)
                        begin
                            head_reg  <= '0;
                            count_reg <= '0;
                            busy_reg  <= '0;
                        end
                        if (in_beg < 0)
                        begin
                            res0_var_reg <= s_axis_tdata[40:33];
                            res0_st_reg  <= lsra_pkg::ST_UNUSED;
                            res0_reg_reg <= '0;
                            state_reg    <= S_EMIT;
                        end
                        else if (count_eff == '0)
                        begin
                            state_reg <= S_DECIDE;
                        end
                        else
                        begin
                            state_reg <= S_EXP_CHK;
                        end
                    end
                end
                S_EXP_CHK:
                begin
                    if (expire_hit)
                    begin
                        busy_reg[rd_reg] <= 1'b0;
                        head_reg         <= head_inc;
                        count_reg        <= count_reg - CW'(1);
                        if (count_reg == CW'(1))
                        begin
                            state_reg <= S_DECIDE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    res0_var_reg <= var_reg;
                    res0_reg_reg <= '0;
                    if (count_reg == FULL)
                    begin
                        state_reg <= S_SPILL_CHK;
                    end
                    else if (is_fixed)
                    begin
                        if (fixed_bad)
                        begin
                            res0_st_reg <= lsra_pkg::ST_CONFLICT;
                            state_reg   <= S_EMIT;
                        end
                        else
                        begin
                            busy_reg[var_reg[AW-1:0]] <= 1'b1;
                            new_reg_reg  <= var_reg[AW-1:0];
                            res0_st_reg  <= lsra_pkg::ST_REG;
                            res0_reg_reg <= var_reg[AW-1:0];
                            state_reg    <= S_INS_START;
                        end
                    end
                    else
                    begin
                        scan_reg  <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (!busy_reg[scan_reg])
                    begin
                        busy_reg[scan_reg] <= 1'b1;
                        new_reg_reg  <= scan_reg;
                        res0_st_reg  <= lsra_pkg::ST_REG;
                        res0_reg_reg <= scan_reg;
                        state_reg    <= S_INS_START;
                    end
                    else if (scan_reg == AW'(NUM_REGS - 1))
                    begin
                        res0_st_reg <= lsra_pkg::ST_SPILL;
                        state_reg   <= S_EMIT;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + AW'(1);
                    end
                end
                S_SPILL_CHK:
                begin
                    res0_st_reg <= lsra_pkg::ST_SPILL;
                    if (rd_data.end_pos > end_reg)
                    begin
                        res0_var_reg <= rd_data.var_num;
                        res1_var_reg <= var_reg;
                        res1_st_reg  <= lsra_pkg::ST_REG;
                        res1_reg_reg <= rd_reg;
                        new_reg_reg  <= rd_reg;
                        two_reg      <= 1'b1;
                        count_reg    <= count_reg - CW'(1);
                        state_reg    <= S_INS_START;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_INS_START:
                begin
                    if (count_reg == '0)
                    begin
                        ins_pos_reg <= '0;
                        state_reg   <= S_INS_WR;
                    end
                    else
                    begin
                        pos_reg   <= count_reg - CW'(1);
                        state_reg <= S_INS_CHK;
                    end
                end
                S_INS_CHK:
                begin
                    if (rd_data.end_pos >= end_reg)
                    begin
                        if (pos_reg == '0)
                        begin
                            ins_pos_reg <= '0;
                            state_reg   <= S_INS_WR;
                        end
                        else
                        begin
                            pos_reg <= pos_reg - CW'(1);
                        end
                    end
                    else
                    begin
                        ins_pos_reg <= pos_reg + CW'(1);
                        state_reg   <= S_INS_WR;
                    end
                end
                S_INS_WR:
                begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_var_reg   <= sel_var;
                        m_st_reg    <= sel_st;
                        m_idx_reg   <= (sel_st == lsra_pkg::ST_REG) ? sel_idx : 4'd0;
                        m_last_reg  <= !two_reg || sent_reg;
                        if (two_reg && !sent_reg)
                        begin
                            sent_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'd0, m_idx_reg, m_var_reg};
    assign m_axis_tuser  = m_st_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire

[src/lsra_mem.sv]
// ----------------------------------------------------------------------------
// lsra_mem
// Active set storage: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsra_mem #(
    parameter int DEPTH = 16
) (
    input  wire logic              clk,
    input  wire lsra_pkg::mem_req_t req,
    output lsra_pkg::entry_t       rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    lsra_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        rd_data <= mem[req.raddr[AW-1:0]];
    end

endmodule

`default_nettype wire

[src/lsra_rot.sv]
// ----------------------------------------------------------------------------
// lsra_rot
// Rotate a register number by the offset, modulo the register count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsra_rot #(
    parameter int NUM_REGS = 16
) (
    input  wire logic [3:0]                    rot,
    input  wire logic [$clog2(NUM_REGS)-1:0]   reg_num,
    output logic [3:0]                         reg_index
);

    localparam int RW = $clog2(NUM_REGS);
    localparam int SW = ((RW > 4) ? RW : 4) + 1;
    localparam logic [SW-1:0] NV = SW'(NUM_REGS);

    logic [SW-1:0] rot_mod;
    logic [SW-1:0] sum;

    always_comb
    begin
        rot_mod = SW'(rot);
        for (int i = 0; i < 8; i++)
        begin
            if (rot_mod >= NV)
            begin
                rot_mod = rot_mod - NV;
            end
        end
        sum = SW'(reg_num) + rot_mod;
        if (sum >= NV)
        begin
            sum = sum - NV;
        end
        reg_index = sum[3:0];
    end

endmodule

`default_nettype wire

[src/lsra_checker.sv]
// ----------------------------------------------------------------------------
// lsra_checker
// Port-level checks on the register allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "linear_scan_register_allocator_defines.svh"

module lsra_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    `LSRA_ASSERT_ALWAYS(a_rst_no_out, !rst_n |-> !m_axis_tvalid, "result beat during reset")

    `LSRA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result beat changed")

    `LSRA_ASSERT(a_idx_zero, m_axis_tvalid && m_axis_tuser != lsra_pkg::ST_REG |-> m_axis_tdata[11:8] == 4'd0, "register index set on a non-assigned result")

    `LSRA_ASSERT(a_first_spill, m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == lsra_pkg::ST_SPILL, "non-final result is not a spill")

    `LSRA_ASSERT(a_busy_after, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "accepted a beat while still working")

endmodule

bind linear_scan_register_allocator lsra_checker u_lsra_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
